### sv/ackrt_pkg.sv
// Shared types and codes of the acknowledgement retransmission tracker.
// Holds field widths, action and result-kind codes, register indexes and
// the slot entry and result record layouts. No dependencies.
package ackrt_pkg;

   // Field widths
   localparam int CRC_W      = 16;
   localparam int TAG_W      = 16;
   localparam int LEN_W      = 9;
   localparam int TIME_W     = 16;
   localparam int TRY_W      = 4;
   localparam int KIND_W     = 4;
   localparam int SLOT_OUT_W = 3;
   localparam int ACT_W      = 2;
   localparam int QFREE_W    = 11;
   localparam int STEP_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ACK      = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_REGISTERED = 4'd0;
   localparam logic [KIND_W-1:0] KIND_DUPLICATE  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_FULL       = 4'd2;
   localparam logic [KIND_W-1:0] KIND_IGNORED    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_ACKED      = 4'd4;
   localparam logic [KIND_W-1:0] KIND_UNMATCHED  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_RESEND     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_BLOCKED    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_GAVE_UP    = 4'd8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_STEP      = 2'd2;

   // Register reset values
   localparam logic [TIME_W-1:0] RST_RETRY_INTERVAL = 16'd100;
   localparam logic [TRY_W-1:0]  RST_MAX_RETRIES    = 4'd3;
   localparam logic [STEP_W-1:0] RST_TICK_STEP      = 8'd10;

   // Smallest frame that may be queued for resend
   localparam int MIN_FRAME = 7;

   // Error flag bit positions
   localparam int ERR_NO_ACK = 0;
   localparam int ERR_FULL   = 1;

   // One table slot as stored in memory
   typedef struct packed {
      logic [CRC_W-1:0]  crc;
      logic [TIME_W-1:0] elapsed;
      logic [TRY_W-1:0]  retry;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  length;
   } entry_type;

   // One result record, without the last marker
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [SLOT_OUT_W-1:0] slot;
      logic [TAG_W-1:0]      tag;
      logic [LEN_W-1:0]      length;
      logic [TRY_W-1:0]      tries;
      logic                  no_ack_error;
      logic                  full_error;
   } result_type;

endpackage

### sv/ackrt_slot_mem.sv
// Slot table storage: one write port and one read port, registered read.
// Depends on ackrt_pkg for the entry layout.
module ackrt_slot_mem import ackrt_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   input  entry_type                              wr_data,
   input  logic                                   rd_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output entry_type                              rd_data
);

   entry_type mem_ff [SLOTS];
   entry_type rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ack_retransmission_tracker.sv
// Acknowledgement retransmission tracker: table of frames awaiting an ack.
// Each scanned slot passes through a read state and an evaluate state, and the last result
// is registered in a flush state; a register or ack request stops at its hit, a tick scans
// all SLOTS, and an ignored register goes straight to the flush. One request at a time: the
// next is taken once the tracker is back in idle after the last result, later while results
// stall. Reset is synchronous: slots idle, flags and registers at defaults, no pass.
module ack_retransmission_tracker import ackrt_pkg::*; #(
   parameter int SLOTS       = 8,
   parameter int MAX_FRAME   = 256,
   parameter int QUEUE_BYTES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [CRC_W-1:0]      req_frame_crc,
   input  logic [TAG_W-1:0]      req_frame_tag,
   input  logic [LEN_W-1:0]      req_frame_length,
   input  logic [QFREE_W-1:0]    req_queue_free,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [TAG_W-1:0]      rsp_out_tag,
   output logic [LEN_W-1:0]      rsp_out_length,
   output logic [TRY_W-1:0]      rsp_tries,
   output logic                  rsp_no_ack_error,
   output logic                  rsp_full_error,
   output logic                  rsp_last,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [SLOTS-1:0]  waiting_ff, waiting_in;
   logic [1:0]        flags_ff, flags_in;
   logic              hold_vld_ff, hold_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] interval_ff, interval_in;
   logic [TRY_W-1:0]  max_retries_ff, max_retries_in;
   logic [STEP_W-1:0] tick_step_ff, tick_step_in;

   // payload state
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [ACT_W-1:0]   action_ff, action_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [QFREE_W-1:0] room_ff, room_in;
   result_type         hold_ff, hold_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_last_ff, rsp_last_in;

   // memory port
   logic              mem_wr_en;
   entry_type         mem_wr_data;
   logic              mem_rd_en;
   entry_type         rd;

   // slot evaluation
   logic                  req_accept;
   logic                  out_free;
   logic                  wait_bit;
   logic                  crc_hit;
   logic                  is_last;
   logic [TIME_W:0]       age_sum;
   logic [TIME_W-1:0]     age_sat;
   logic                  len_ok;
   logic                  emit;
   logic                  stop;
   logic                  set_wait;
   logic                  clr_wait;
   logic [1:0]            flags_new;
   logic [QFREE_W-1:0]    room_next;
   result_type            res;
   logic [31:0]           idx_wide;
   logic [SLOT_OUT_W-1:0] slot_out;
   logic                  commit;

   ackrt_slot_mem #(
      .SLOTS (SLOTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (idx_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mem_rd_en  = (state_ff == ST_READ);

   assign idx_wide = 32'(idx_ff);
   assign slot_out = idx_wide[SLOT_OUT_W-1:0];

   // Evaluate the slot whose entry has just been read
   assign wait_bit = waiting_ff[idx_ff];
   assign crc_hit  = (rd.crc == crc_ff);
   assign is_last  = (idx_ff == LAST_IDX);
   assign age_sum  = {1'b0, rd.elapsed} + (TIME_W + 1)'(tick_step_ff);
   assign age_sat  = age_sum[TIME_W] ? {TIME_W{1'b1}} : age_sum[TIME_W-1:0];
   assign len_ok   = (32'(rd.length) >= MIN_FRAME) && (32'(rd.length) <= MAX_FRAME)
                     && (room_ff >= QFREE_W'(rd.length));

   always_comb begin
      emit        = 1'b0;
      stop        = 1'b0;
      set_wait    = 1'b0;
      clr_wait    = 1'b0;
      mem_wr_data = rd;
      flags_new   = flags_ff;
      room_next   = room_ff;
      res         = '0;
      res.slot    = slot_out;
      res.tag     = rd.tag;
      res.length  = rd.length;
      case (action_ff)
         ACT_REGISTER: begin
            if (!wait_bit) begin
               set_wait            = 1'b1;
               mem_wr_data.crc     = crc_ff;
               mem_wr_data.elapsed = '0;
               mem_wr_data.retry   = '0;
               mem_wr_data.tag     = tag_ff;
               mem_wr_data.length  = len_ff;
               emit                = 1'b1;
               stop                = 1'b1;
               res.kind            = KIND_REGISTERED;
               res.tag             = tag_ff;
               res.length          = len_ff;
            end else if (crc_hit) begin
               emit      = 1'b1;
               stop      = 1'b1;
               res.kind  = KIND_DUPLICATE;
               res.tries = rd.retry;
            end else if (is_last) begin
               flags_new[ERR_FULL] = 1'b1;
               emit                = 1'b1;
               res                 = '0;
               res.kind            = KIND_FULL;
            end
         end
         ACT_ACK: begin
            if (wait_bit && crc_hit) begin
               clr_wait = 1'b1;
               emit     = 1'b1;
               stop     = 1'b1;
               res.kind = KIND_ACKED;
            end else if (is_last) begin
               emit     = 1'b1;
               res      = '0;
               res.kind = KIND_UNMATCHED;
            end
         end
         ACT_TICK: begin
            if (wait_bit) begin
               mem_wr_data.elapsed = age_sat;
               if (age_sat >= interval_ff) begin
                  emit = 1'b1;
                  if (rd.retry < max_retries_ff) begin
                     if (len_ok) begin
                        room_next           = room_ff - QFREE_W'(rd.length);
                        mem_wr_data.retry   = rd.retry + 1'b1;
                        mem_wr_data.elapsed = '0;
                        res.kind            = KIND_RESEND;
                        res.tries           = rd.retry + 1'b1;
                     end else begin
                        flags_new[ERR_NO_ACK] = 1'b1;
                        res.kind              = KIND_BLOCKED;
                        res.tries             = rd.retry;
                     end
                  end else begin
                     clr_wait = 1'b1;
                     res.kind = KIND_GAVE_UP;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.no_ack_error = flags_new[ERR_NO_ACK];
      res.full_error   = flags_new[ERR_FULL];
   end

   // Evaluation commits unless it must push the held result into a busy output
   assign commit    = !emit || !hold_vld_ff || out_free;
   assign mem_wr_en = (state_ff == ST_EVAL) && commit && (action_ff == ACT_TICK ?
                      wait_bit : set_wait);

   // Sequence the scan and the result hand-off
   always_comb begin
      state_in       = state_ff;
      waiting_in     = waiting_ff;
      flags_in       = flags_ff;
      hold_vld_in    = hold_vld_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      interval_in    = interval_ff;
      max_retries_in = max_retries_ff;
      tick_step_in   = tick_step_ff;
      idx_in         = idx_ff;
      action_in      = action_ff;
      crc_in         = crc_ff;
      tag_in         = tag_ff;
      len_in         = len_ff;
      room_in        = room_ff;
      hold_in        = hold_ff;
      rsp_in         = rsp_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_RETRY_INTERVAL: interval_in    = csr_data;
            CSR_MAX_RETRIES:    max_retries_in = csr_data[TRY_W-1:0];
            CSR_TICK_STEP:      tick_step_in   = csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_action;
               crc_in    = req_frame_crc;
               tag_in    = req_frame_tag;
               len_in    = req_frame_length;
               idx_in    = '0;
               room_in   = (32'(req_queue_free) > QUEUE_BYTES) ? QFREE_W'(QUEUE_BYTES)
                                                               : req_queue_free;
               if (req_action == ACT_REGISTER && req_frame_length == '0) begin
                  hold_in                  = '0;
                  hold_in.kind             = KIND_IGNORED;
                  hold_in.no_ack_error     = flags_ff[ERR_NO_ACK];
                  hold_in.full_error       = flags_ff[ERR_FULL];
                  hold_vld_in              = 1'b1;
                  state_in                 = ST_FLUSH;
               end else if (req_action == ACT_REGISTER || req_action == ACT_ACK ||
                            req_action == ACT_TICK) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (commit) begin
               if (set_wait) begin
                  waiting_in[idx_ff] = 1'b1;
               end
               if (clr_wait) begin
                  waiting_in[idx_ff] = 1'b0;
               end
               flags_in = flags_new;
               room_in  = room_next;
               if (emit) begin
                  // push the older result out, keep the newest one back
                  if (hold_vld_ff) begin
                     rsp_in       = hold_ff;
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  hold_in     = res;
                  hold_vld_in = 1'b1;
               end
               if (stop || is_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in       = hold_ff;
               rsp_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               hold_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         waiting_ff     <= '0;
         flags_ff       <= '0;
         hold_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         interval_ff    <= RST_RETRY_INTERVAL;
         max_retries_ff <= RST_MAX_RETRIES;
         tick_step_ff   <= RST_TICK_STEP;
      end else begin
         state_ff       <= state_in;
         waiting_ff     <= waiting_in;
         flags_ff       <= flags_in;
         hold_vld_ff    <= hold_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         interval_ff    <= interval_in;
         max_retries_ff <= max_retries_in;
         tick_step_ff   <= tick_step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      action_ff   <= action_in;
      crc_ff      <= crc_in;
      tag_ff      <= tag_in;
      len_ff      <= len_in;
      room_ff     <= room_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_slot         = rsp_ff.slot;
   assign rsp_out_tag      = rsp_ff.tag;
   assign rsp_out_length   = rsp_ff.length;
   assign rsp_tries        = rsp_ff.tries;
   assign rsp_no_ack_error = rsp_ff.no_ack_error;
   assign rsp_full_error   = rsp_ff.full_error;
   assign rsp_last         = rsp_last_ff;

endmodule

### sv/ackrt_checker.sv
// Port-level checks of the acknowledgement retransmission tracker, bound
// to the top level. Depends on ackrt_pkg for widths and result kinds.
module ackrt_checker import ackrt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [KIND_W-1:0]     rsp_kind,
   input logic [SLOT_OUT_W-1:0] rsp_slot,
   input logic [TAG_W-1:0]      rsp_out_tag,
   input logic [LEN_W-1:0]      rsp_out_length,
   input logic [TRY_W-1:0]      rsp_tries,
   input logic                  rsp_no_ack_error,
   input logic                  rsp_full_error,
   input logic                  rsp_last
);

   logic rsp_accept;
   logic seen_full_ff;
   logic seen_no_ack_ff;

   assign rsp_accept = rsp_valid && !rsp_stall;

   // Remember sticky flags seen on delivered results
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_full_ff   <= 1'b0;
         seen_no_ack_ff <= 1'b0;
      end else if (rsp_accept) begin
         seen_full_ff   <= seen_full_ff || rsp_full_error;
         seen_no_ack_ff <= seen_no_ack_ff || rsp_no_ack_error;
      end
   end

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
         && $stable(rsp_out_tag) && $stable(rsp_out_length) && $stable(rsp_tries)
         && $stable(rsp_no_ack_error) && $stable(rsp_full_error) && $stable(rsp_last))
      else $error("stalled result changed");

   // The table-full flag never drops once reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_accept && seen_full_ff |-> rsp_full_error)
      else $error("full error flag dropped");

   // The no-ack flag never drops once reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_accept && seen_no_ack_ff |-> rsp_no_ack_error)
      else $error("no-ack error flag dropped");

   // Register and ack requests give a single, final result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind < KIND_RESEND |-> rsp_last)
      else $error("single-result request not marked last");

   // Fresh, acked and dropped slots report no retries
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REGISTERED || rsp_kind == KIND_ACKED ||
                    rsp_kind == KIND_GAVE_UP) |-> rsp_tries == '0)
      else $error("nonzero retry count on cleared slot");

endmodule

bind ack_retransmission_tracker ackrt_checker u_ackrt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_slot         (rsp_slot),
   .rsp_out_tag      (rsp_out_tag),
   .rsp_out_length   (rsp_out_length),
   .rsp_tries        (rsp_tries),
   .rsp_no_ack_error (rsp_no_ack_error),
   .rsp_full_error   (rsp_full_error),
   .rsp_last         (rsp_last)
);
